>>> src/clock_tube_digit_formatter_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the tube digit formatter
// Concurrent checks clocked on i_clk and disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef CLOCK_TUBE_DIGIT_FORMATTER_ASSERT_SVH
`define CLOCK_TUBE_DIGIT_FORMATTER_ASSERT_SVH

// Same-cycle implication.
`define CTDF_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CTDF_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> src/ctdf_pkg.sv
// ---------------------------------------------------------------------------
// ctdf_pkg
// Types, codes and helper functions for the tube digit formatter.
// ---------------------------------------------------------------------------
package ctdf_pkg;

    typedef logic [3:0] t_digit;

    typedef struct packed {
        t_digit tens;
        t_digit units;
    } t_bcd2;

    // tube code for an unlit tube
    localparam t_digit BLANK = 4'd10;

    // mode codes
    localparam logic [1:0] MODE_TIME = 2'd0;
    localparam logic [1:0] MODE_DATE = 2'd1;
    localparam logic [1:0] MODE_TEMP = 2'd2;

    // date order codes
    localparam logic [1:0] ORDER_DAY_FIRST   = 2'd0;
    localparam logic [1:0] ORDER_YEAR_FIRST  = 2'd1;
    localparam logic [1:0] ORDER_MONTH_FIRST = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_HOUR_24       = 2'd0;
    localparam logic [1:0] CFG_DATE_ORDER    = 2'd1;
    localparam logic [1:0] CFG_COMPACT_TEMP  = 2'd2;
    localparam logic [1:0] CFG_POISON_PERIOD = 2'd3;

    localparam int CFG_DATA_W = 7;

    // reset values
    localparam logic       RST_HOUR_24       = 1'b1;
    localparam logic [1:0] RST_DATE_ORDER    = ORDER_DAY_FIRST;
    localparam logic       RST_COMPACT_TEMP  = 1'b0;
    localparam logic [6:0] RST_POISON_PERIOD = 7'd30;

    localparam logic [4:0] HOUR_HALF         = 5'd12;
    localparam logic [6:0] POISON_HOUR_BASE  = 7'd100;
    localparam logic [5:0] SLOT_SECOND_LIMIT = 6'd30;
    localparam logic [13:0] TEMP_MAX         = 14'd9999;

    // x / 100 == (x * DIV100_MUL) >> DIV100_SHIFT, exact for x < 43690
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;
    localparam logic [6:0]  HUNDRED      = 7'd100;

    // tens and units of a value below 100
    function automatic t_bcd2 split2(input logic [6:0] x);
        t_bcd2      r;
        t_digit     tens;
        logic [6:0] tens_x10;
        tens = '0;
        for (int k = 1; k < 10; k++) begin
            if (x >= 7'(10 * k)) tens = tens + 4'd1;
        end
        tens_x10 = {tens, 3'b000} + {2'b00, tens, 1'b0};
        r.tens   = tens;
        r.units  = 4'(x - tens_x10);
        return r;
    endfunction

    // one restoring-division step; rem stays below the divisor
    function automatic logic [6:0] div_step(input logic [6:0] rem, input logic bit_in,
                                            input logic [6:0] dvs);
        logic [7:0] tmp;
        tmp = {rem, bit_in};
        if (tmp >= {1'b0, dvs}) tmp = tmp - {1'b0, dvs};
        return tmp[6:0];
    endfunction

endpackage

>>> src/clock_tube_digit_formatter.sv
// ---------------------------------------------------------------------------
// clock_tube_digit_formatter
// Six-tube digit formatter: time, date or temperature view per input word.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries one clock reading per word:
//   mode, time, date and temperature. Output channel (o_valid / i_stall)
//   returns one word per input: six tube codes (10 = blank), the right
//   comma mask and the anti-poisoning slot flag.
//   Config port (i_cfg_we, i_cfg_idx, i_cfg_data) writes hour_24, date_order,
//   compact_temp and poison_period; write only while the block is empty.
//   Three register stages lie between acceptance and o_valid: split/scale,
//   digit extraction, view assembly.
//   Throughput is one word per cycle while i_stall is low; each stage moves
//   whenever the stage after it is empty or moving, so bubbles close up.
//   When the receiver stalls, the output register holds its word and the
//   stages behind fill; o_stall rises only once all three stages are full.
//   Reset (synchronous, i_rst_n low) empties the pipeline and loads the
//   register defaults: 24-hour, day-month-year, separate comma tube,
//   poison period 30 minutes.
// ---------------------------------------------------------------------------
`include "clock_tube_digit_formatter_assert.svh"

module clock_tube_digit_formatter
    import ctdf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config port
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [1:0]            i_mode,
    input  logic [4:0]            i_hour,
    input  logic [5:0]            i_minute,
    input  logic [5:0]            i_second,
    input  logic [4:0]            i_day,
    input  logic [3:0]            i_month,
    input  logic [13:0]           i_year,
    input  logic signed [14:0]    i_temp_centi,
    // output channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [3:0]            o_tube0,
    output logic [3:0]            o_tube1,
    output logic [3:0]            o_tube2,
    output logic [3:0]            o_tube3,
    output logic [3:0]            o_tube4,
    output logic [3:0]            o_tube5,
    output logic [5:0]            o_right_commas,
    output logic                  o_poison_slot
);

    // ---------------- configuration registers ----------------
    logic       r_hour_24;
    logic [1:0] r_date_order;
    logic       r_compact_temp;
    logic [6:0] r_poison_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hour_24       <= RST_HOUR_24;
            r_date_order    <= RST_DATE_ORDER;
            r_compact_temp  <= RST_COMPACT_TEMP;
            r_poison_period <= RST_POISON_PERIOD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HOUR_24:       r_hour_24       <= i_cfg_data[0];
                CFG_DATE_ORDER:    r_date_order    <= i_cfg_data[1:0];
                CFG_COMPACT_TEMP:  r_compact_temp  <= i_cfg_data[0];
                CFG_POISON_PERIOD: r_poison_period <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline flow control ----------------
    // a stage loads when it is empty or its word moves on this edge
    logic r_s1_valid, r_s2_valid, r_s3_valid;
    logic w_rdy1, w_rdy2, w_rdy3;

    assign w_rdy3  = !r_s3_valid || !i_stall;
    assign w_rdy2  = !r_s2_valid || w_rdy3;
    assign w_rdy1  = !r_s1_valid || w_rdy2;
    assign o_stall = !w_rdy1;
    assign o_valid = r_s3_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (w_rdy1) r_s1_valid <= i_valid;
            if (w_rdy2) r_s2_valid <= r_s1_valid;
            if (w_rdy3) r_s3_valid <= r_s2_valid;
        end
    end

    // ---------------- stage 1: scale and select ----------------
    // 12-hour fold, temperature clamp, /100 of year and temperature by
    // reciprocal multiply, operand pick for the slot divisibility test
    logic [4:0]  n_s1_hour;
    logic [13:0] n_s1_temp;
    logic [26:0] w_year_prod;
    logic [26:0] w_temp_prod;
    logic        w_hour_path;
    logic        n_s1_slot_en;
    logic [5:0]  n_s1_dvd;
    logic [6:0]  n_s1_dvs;

    always_comb begin
        n_s1_hour = i_hour;
        if (!r_hour_24 && (i_hour > HOUR_HALF)) n_s1_hour = i_hour - HOUR_HALF;

        if (i_temp_centi[14])                 n_s1_temp = '0;
        else if (i_temp_centi[13:0] > TEMP_MAX) n_s1_temp = TEMP_MAX;
        else                                  n_s1_temp = i_temp_centi[13:0];

        w_year_prod = 27'(i_year) * 27'(DIV100_MUL);
        w_temp_prod = 27'(n_s1_temp) * 27'(DIV100_MUL);

        // hourly slots test the hour, otherwise the minute
        w_hour_path  = (r_poison_period > POISON_HOUR_BASE) && (i_minute == '0)
                       && (i_second < SLOT_SECOND_LIMIT);
        n_s1_slot_en = (r_poison_period != '0) && (i_second < SLOT_SECOND_LIMIT);
        n_s1_dvd     = w_hour_path ? {1'b0, i_hour} : i_minute;
        n_s1_dvs     = w_hour_path ? (r_poison_period - POISON_HOUR_BASE) : r_poison_period;
    end

    logic [1:0] r_s1_mode;
    logic [4:0] r_s1_hour;
    logic [5:0] r_s1_minute, r_s1_second;
    logic [4:0] r_s1_day;
    logic [3:0] r_s1_month;
    logic [7:0] r_s1_year_q;
    logic [6:0] r_s1_year_lo;
    logic [6:0] r_s1_temp_q;
    logic [6:0] r_s1_temp_lo;
    logic       r_s1_slot_en;
    logic [5:0] r_s1_dvd;
    logic [6:0] r_s1_dvs;

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_s1_mode    <= i_mode;
            r_s1_hour    <= n_s1_hour;
            r_s1_minute  <= i_minute;
            r_s1_second  <= i_second;
            r_s1_day     <= i_day;
            r_s1_month   <= i_month;
            r_s1_year_q  <= w_year_prod[DIV100_SHIFT+7:DIV100_SHIFT];
            r_s1_year_lo <= i_year[6:0];
            r_s1_temp_q  <= w_temp_prod[DIV100_SHIFT+6:DIV100_SHIFT];
            r_s1_temp_lo <= n_s1_temp[6:0];
            r_s1_slot_en <= n_s1_slot_en;
            r_s1_dvd     <= n_s1_dvd;
            r_s1_dvs     <= n_s1_dvs;
        end
    end

    // ---------------- stage 2: remainders and small digits ----------------
    // remainder below 100 is exact in the low 7 bits
    logic [14:0] w_year_q100;
    logic [13:0] w_temp_q100;
    logic [6:0]  n_s2_year_r;
    logic [6:0]  n_s2_temp_r;
    logic [6:0]  n_s2_rem;

    always_comb begin
        w_year_q100 = 15'(r_s1_year_q) * 15'(HUNDRED);
        w_temp_q100 = 14'(r_s1_temp_q) * 14'(HUNDRED);
        n_s2_year_r = r_s1_year_lo - w_year_q100[6:0];
        n_s2_temp_r = r_s1_temp_lo - w_temp_q100[6:0];
        // upper three dividend bits of the slot test
        n_s2_rem = div_step(7'd0, r_s1_dvd[5], r_s1_dvs);
        n_s2_rem = div_step(n_s2_rem, r_s1_dvd[4], r_s1_dvs);
        n_s2_rem = div_step(n_s2_rem, r_s1_dvd[3], r_s1_dvs);
    end

    logic [1:0] r_s2_mode;
    t_bcd2      r_s2_hour, r_s2_minute, r_s2_second, r_s2_day, r_s2_month;
    logic [6:0] r_s2_year_r;
    logic [6:0] r_s2_temp_q;
    logic [6:0] r_s2_temp_r;
    logic       r_s2_slot_en;
    logic [6:0] r_s2_rem;
    logic [2:0] r_s2_dvd_lo;
    logic [6:0] r_s2_dvs;

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_s2_mode    <= r_s1_mode;
            r_s2_hour    <= split2(7'(r_s1_hour));
            r_s2_minute  <= split2(7'(r_s1_minute));
            r_s2_second  <= split2(7'(r_s1_second));
            r_s2_day     <= split2(7'(r_s1_day));
            r_s2_month   <= split2(7'(r_s1_month));
            r_s2_year_r  <= n_s2_year_r;
            r_s2_temp_q  <= r_s1_temp_q;
            r_s2_temp_r  <= n_s2_temp_r;
            r_s2_slot_en <= r_s1_slot_en;
            r_s2_rem     <= n_s2_rem;
            r_s2_dvd_lo  <= r_s1_dvd[2:0];
            r_s2_dvs     <= r_s1_dvs;
        end
    end

    // ---------------- stage 3: view assembly ----------------
    t_bcd2      w_yy, w_tq, w_tr, w_da, w_db, w_dc;
    logic [6:0] w_rem;
    t_digit     n_tube [0:5];
    logic [5:0] n_commas;
    logic       n_slot;

    always_comb begin
        w_yy = split2(r_s2_year_r);
        w_tq = split2(r_s2_temp_q);
        w_tr = split2(r_s2_temp_r);

        w_rem = div_step(r_s2_rem, r_s2_dvd_lo[2], r_s2_dvs);
        w_rem = div_step(w_rem, r_s2_dvd_lo[1], r_s2_dvs);
        w_rem = div_step(w_rem, r_s2_dvd_lo[0], r_s2_dvs);

        // date fields in display order; unused order code falls to DMY
        unique case (r_date_order)
            ORDER_YEAR_FIRST: begin
                w_da = w_yy;       w_db = r_s2_month; w_dc = r_s2_day;
            end
            ORDER_MONTH_FIRST: begin
                w_da = r_s2_month; w_db = r_s2_day;   w_dc = w_yy;
            end
            default: begin
                w_da = r_s2_day;   w_db = r_s2_month; w_dc = w_yy;
            end
        endcase

        for (int i = 0; i < 6; i++) n_tube[i] = BLANK;
        n_commas = '0;
        n_slot   = 1'b0;

        unique case (r_s2_mode)
            MODE_TIME: begin
                if (r_s2_second.tens[0]) begin
                    // odd seconds tens: MMSS, last two tubes dark
                    n_tube[0] = r_s2_minute.tens;
                    n_tube[1] = r_s2_minute.units;
                    n_tube[2] = r_s2_second.tens;
                    n_tube[3] = r_s2_second.units;
                end else begin
                    n_tube[0] = r_s2_hour.tens;
                    n_tube[1] = r_s2_hour.units;
                    n_tube[2] = r_s2_minute.tens;
                    n_tube[3] = r_s2_minute.units;
                    n_tube[4] = r_s2_second.tens;
                    n_tube[5] = r_s2_second.units;
                end
                n_slot = r_s2_slot_en && (w_rem == '0);
            end
            MODE_DATE: begin
                n_tube[0] = w_da.tens;
                n_tube[1] = w_da.units;
                n_tube[2] = w_db.tens;
                n_tube[3] = w_db.units;
                n_tube[4] = w_dc.tens;
                n_tube[5] = w_dc.units;
            end
            MODE_TEMP: begin
                // leading zero stays dark in place
                if (r_compact_temp) begin
                    n_tube[2] = (w_tq.tens == '0) ? BLANK : w_tq.tens;
                    n_tube[3] = w_tq.units;
                end else begin
                    n_tube[1] = (w_tq.tens == '0) ? BLANK : w_tq.tens;
                    n_tube[2] = w_tq.units;
                end
                n_tube[4] = w_tr.tens;
                n_tube[5] = w_tr.units;
                n_commas  = 6'b001000;
            end
            default: ;
        endcase
    end

    t_digit     r_s3_tube [0:5];
    logic [5:0] r_s3_commas;
    logic       r_s3_slot;

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            for (int i = 0; i < 6; i++) r_s3_tube[i] <= n_tube[i];
            r_s3_commas <= n_commas;
            r_s3_slot   <= n_slot;
        end
    end

    assign o_tube0        = r_s3_tube[0];
    assign o_tube1        = r_s3_tube[1];
    assign o_tube2        = r_s3_tube[2];
    assign o_tube3        = r_s3_tube[3];
    assign o_tube4        = r_s3_tube[4];
    assign o_tube5        = r_s3_tube[5];
    assign o_right_commas = r_s3_commas;
    assign o_poison_slot  = r_s3_slot;

    // ---------------- assertions ----------------
    `CTDF_CHECK(a_stall_full, o_stall, r_s1_valid && r_s2_valid && r_s3_valid,
        "input stalled with an empty stage")
    `CTDF_CHECK_NEXT(a_s2_hold, r_s2_valid && r_s3_valid && i_stall, r_s2_valid,
        "stage 2 word lost under stall")
    `CTDF_CHECK(a_comma_tube3, o_valid && (o_right_commas != '0), o_right_commas == 6'b001000,
        "comma lit outside tube 3")
    `CTDF_CHECK(a_slot_no_comma, o_valid && o_poison_slot, o_right_commas == '0,
        "slot flag outside time view")
    `CTDF_CHECK(a_tube_code, o_valid, (o_tube0 <= BLANK) && (o_tube5 <= BLANK),
        "tube code out of range")

endmodule
